>>> sv/infix_expression_evaluator_defines.svh
// Assertion macros used by the evaluator datapath.
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
// Condition that holds at every clock edge out of reset.
`define IEE_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Same-cycle implication.
`define IEE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define IEE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`endif

>>> sv/iee_pkg.sv
// Shared types, codes, tables and helper functions of the expression evaluator.
package iee_pkg;

  localparam int VALUE_W = 48;

  typedef logic signed [VALUE_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SYNTAX    = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_DIV_ZERO  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_END  = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_OPEN = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MD_CONV,
    MD_MUL,
    MD_DIV
  } md_mode_e;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef struct packed {
    logic      num_digit;
    logic      num_point;
    logic      num_clear;
    logic      md_start;
    md_mode_e  md_mode;
    logic      opd_push;
    logic      opd_read;
    logic      opd_reduce;
    logic      red_from_md;
    logic      alu_sub;
    logic      op_read;
    logic      op_push;
    op_e       op_code;
    logic      op_pop;
    logic      clear;
    logic      emit;
    status_e   emit_status;
  } dp_cmd_t;

  typedef struct packed {
    logic point_seen;
    logic digit_seen;
    logic op_full;
    logic opd_full;
    logic opd_lt2;
    logic opd_is1;
    op_e  top;
    logic b_zero;
    logic md_done;
    logic out_busy;
  } dp_sts_t;

  function automatic logic [23:0] pow10(input logic [2:0] fd);
    logic [23:0] p;
    case (fd)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

  // Apply sign to a magnitude, saturating when it does not fit.
  function automatic val_t sat_mag(input logic neg, input logic big,
                                   input logic [VALUE_W-2:0] m);
    val_t r;
    if (big) r = neg ? VAL_MIN : VAL_MAX;
    else if (neg) r = val_t'(-$signed({1'b0, m}));
    else r = val_t'({1'b0, m});
    return r;
  endfunction

endpackage

>>> sv/iee_if.sv
// Handshake channels of the evaluator: character input and result output.
interface iee_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface iee_res_if;
  logic               valid;
  logic               ready;
  iee_pkg::val_t      value;
  logic [2:0]         status;
  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

>>> sv/iee_muldiv.sv
// Iterative fixed-point multiplier, bit-serial divider and number converter for the evaluator.
module iee_muldiv #(
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  iee_pkg::md_mode_e mode_i,
  input  iee_pkg::val_t     a_i,
  input  iee_pkg::val_t     b_i,
  input  logic [46:0]       mant_i,
  input  logic [2:0]        fd_i,
  output logic              done_o,
  output iee_pkg::val_t     result_o
);
  import iee_pkg::*;

  localparam int NW = VALUE_W + FRACTION_BITS;
  localparam int KW = $clog2(NW + 1);
  localparam int HW = VALUE_W / 2;

  logic              busy_q;
  md_mode_e          mode_q;
  logic [KW-1:0]     cnt_q;
  logic              neg_q;
  logic [VALUE_W-1:0] ma_q, mb_q;
  logic [VALUE_W-1:0] prod_q;
  logic [2*VALUE_W-1:0] acc_q;
  logic [NW-1:0]     dvd_q;
  logic [VALUE_W-1:0] rem_q;
  logic [VALUE_W-1:0] quo_q;
  logic              big_q;

  logic [1:0]        pidx;
  logic [2*VALUE_W-1:0] sh_prod;
  logic [VALUE_W:0]  trial;
  logic              ge;
  logic [23:0]       p;
  logic              big;
  logic [VALUE_W-2:0] m;
  logic [VALUE_W-1:0] abs_a, abs_b;

  assign abs_a = a_i[VALUE_W-1] ? VALUE_W'(-a_i) : VALUE_W'(a_i);
  assign abs_b = b_i[VALUE_W-1] ? VALUE_W'(-b_i) : VALUE_W'(b_i);
  assign p     = pow10(fd_i);

  assign done_o = busy_q && ((mode_q == MD_MUL) ? (cnt_q == KW'(5)) : (cnt_q == KW'(NW)));

  assign pidx = 2'(cnt_q - KW'(1));
  always_comb begin
    case (pidx)
      2'd0:    sh_prod = {{VALUE_W{1'b0}}, prod_q};
      2'd3:    sh_prod = {prod_q, {VALUE_W{1'b0}}};
      default: sh_prod = {{HW{1'b0}}, prod_q, {HW{1'b0}}};
    endcase
  end

  assign trial = {rem_q, dvd_q[NW-1]};
  assign ge    = trial >= {1'b0, mb_q};

  always_comb begin
    if (mode_q == MD_MUL) begin
      big = |acc_q[2*VALUE_W-1:VALUE_W-1+FRACTION_BITS];
      m   = acc_q[VALUE_W-2+FRACTION_BITS:FRACTION_BITS];
    end else begin
      big = big_q | quo_q[VALUE_W-1];
      m   = quo_q[VALUE_W-2:0];
    end
  end
  assign result_o = sat_mag(neg_q, big, m);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mode_q <= MD_CONV;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      mode_q <= mode_i;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (done_o) busy_q <= 1'b0;
      else cnt_q <= cnt_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= '0;
      big_q <= 1'b0;
      acc_q <= '0;
      case (mode_i)
        MD_MUL: begin
          ma_q  <= abs_a;
          mb_q  <= abs_b;
          neg_q <= a_i[VALUE_W-1] ^ b_i[VALUE_W-1];
        end
        MD_DIV: begin
          mb_q  <= abs_b;
          dvd_q <= {abs_a, {FRACTION_BITS{1'b0}}};
          neg_q <= a_i[VALUE_W-1] ^ b_i[VALUE_W-1];
        end
        default: begin
          // round half up: add half the divisor before dividing
          mb_q  <= VALUE_W'(p);
          dvd_q <= {1'b0, mant_i, {FRACTION_BITS{1'b0}}} + NW'(p >> 1);
          neg_q <= 1'b0;
        end
      endcase
    end else if (busy_q && !done_o) begin
      if (mode_q == MD_MUL) begin
        if (cnt_q < KW'(4)) begin
          prod_q <= (cnt_q[0] ? ma_q[VALUE_W-1:HW] : ma_q[HW-1:0]) *
                    (cnt_q[1] ? mb_q[VALUE_W-1:HW] : mb_q[HW-1:0]);
        end
        if (cnt_q != '0) acc_q <= acc_q + sh_prod;
      end else begin
        rem_q <= ge ? VALUE_W'(trial - {1'b0, mb_q}) : VALUE_W'(trial);
        dvd_q <= dvd_q << 1;
        quo_q <= {quo_q[VALUE_W-2:0], ge};
        big_q <= big_q | quo_q[VALUE_W-1];
      end
    end
  end

endmodule

>>> sv/iee_datapath.sv
// Evaluator datapath: number builder, both stacks, adder/subtractor, multiply/divide unit and result register.
`include "infix_expression_evaluator_defines.svh"
module iee_datapath #(
  parameter int STACK_DEPTH         = 64,
  parameter int FRACTION_BITS       = 16,
  parameter int MAX_FRACTION_DIGITS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iee_pkg::dp_cmd_t  cmd_i,
  output iee_pkg::dp_sts_t  sts_o,
  input  logic [7:0]        char_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output iee_pkg::val_t     res_value_o,
  output logic [2:0]        res_status_o
);
  import iee_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [CW-1:0] opcnt_q, opdcnt_q;
  logic [46:0]   mant_q;
  logic [2:0]    fd_q;
  logic          point_q, digit_q;
  op_e           top_q;
  val_t          a_q, b_q;
  logic          out_valid_q;
  val_t          out_value_q;
  status_e       out_status_q;

  op_e  op_mem  [STACK_DEPTH];
  val_t opd_mem [STACK_DEPTH];

  logic [3:0]    digit;
  logic [50:0]   mant_x10;
  logic [46:0]   mant_next;
  logic          frac_full;
  logic [VALUE_W:0] sum;
  val_t          alu_res, red_res, md_res;
  logic          md_done;
  logic [AW-1:0] op_rd_idx, op_wr_idx, opd_top_idx, opd_nxt_idx, opd_push_idx;

  assign digit     = 4'(char_i - CH_ZERO);
  assign mant_x10  = ({4'b0, mant_q} << 3) + ({4'b0, mant_q} << 1) + 51'(digit);
  assign mant_next = (mant_x10 > 51'({47{1'b1}})) ? {47{1'b1}} : mant_x10[46:0];
  assign frac_full = point_q && (fd_q >= 3'(MAX_FRACTION_DIGITS));

  assign sum = cmd_i.alu_sub ? ({a_q[VALUE_W-1], a_q} - {b_q[VALUE_W-1], b_q})
                             : ({a_q[VALUE_W-1], a_q} + {b_q[VALUE_W-1], b_q});
  assign alu_res = (sum[VALUE_W] != sum[VALUE_W-1]) ? (sum[VALUE_W] ? VAL_MIN : VAL_MAX)
                                                    : val_t'(sum[VALUE_W-1:0]);
  assign red_res = cmd_i.red_from_md ? md_res : alu_res;

  assign op_rd_idx    = AW'(opcnt_q - CW'(1));
  assign op_wr_idx    = AW'(opcnt_q);
  assign opd_top_idx  = AW'(opdcnt_q - CW'(1));
  assign opd_nxt_idx  = AW'(opdcnt_q - CW'(2));
  assign opd_push_idx = AW'(opdcnt_q);

  iee_muldiv #(.FRACTION_BITS(FRACTION_BITS)) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.md_start),
    .mode_i   (cmd_i.md_mode),
    .a_i      (a_q),
    .b_i      (b_q),
    .mant_i   (mant_q),
    .fd_i     (fd_q),
    .done_o   (md_done),
    .result_o (md_res)
  );

  // The bottom operator entry is never written; it reads as the end marker.
  always_comb begin
    sts_o.point_seen = point_q;
    sts_o.digit_seen = digit_q;
    sts_o.op_full    = opcnt_q >= CW'(STACK_DEPTH);
    sts_o.opd_full   = opdcnt_q >= CW'(STACK_DEPTH);
    sts_o.opd_lt2    = opdcnt_q < CW'(2);
    sts_o.opd_is1    = opdcnt_q == CW'(1);
    sts_o.top        = (opcnt_q == CW'(1)) ? OP_END : top_q;
    sts_o.b_zero     = b_q == '0;
    sts_o.md_done    = md_done;
    sts_o.out_busy   = out_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_push) op_mem[op_wr_idx] <= cmd_i.op_code;
    if (cmd_i.op_read) top_q <= op_mem[op_rd_idx];
    if (cmd_i.opd_push) opd_mem[opd_push_idx] <= md_res;
    else if (cmd_i.opd_reduce) opd_mem[opd_nxt_idx] <= red_res;
    if (cmd_i.opd_read) begin
      b_q <= opd_mem[opd_top_idx];
      a_q <= opd_mem[opd_nxt_idx];
    end
    if (cmd_i.emit) begin
      out_value_q  <= (cmd_i.emit_status == ST_OK) ? b_q : '0;
      out_status_q <= cmd_i.emit_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opcnt_q     <= CW'(1);
      opdcnt_q    <= '0;
      mant_q      <= '0;
      fd_q        <= '0;
      point_q     <= 1'b0;
      digit_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        opcnt_q  <= CW'(1);
        opdcnt_q <= '0;
        mant_q   <= '0;
        fd_q     <= '0;
        point_q  <= 1'b0;
        digit_q  <= 1'b0;
      end else begin
        if (cmd_i.num_clear) begin
          mant_q  <= '0;
          fd_q    <= '0;
          point_q <= 1'b0;
          digit_q <= 1'b0;
        end else if (cmd_i.num_digit) begin
          digit_q <= 1'b1;
          // drop digits past the fraction limit
          if (!frac_full) begin
            mant_q <= mant_next;
            if (point_q) fd_q <= fd_q + 3'd1;
          end
        end else if (cmd_i.num_point) begin
          point_q <= 1'b1;
        end
        if (cmd_i.op_push) opcnt_q <= opcnt_q + CW'(1);
        else if (cmd_i.op_pop) opcnt_q <= opcnt_q - CW'(1);
        if (cmd_i.opd_push) opdcnt_q <= opdcnt_q + CW'(1);
        else if (cmd_i.opd_reduce) opdcnt_q <= opdcnt_q - CW'(1);
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (res_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_value_o  = out_value_q;
  assign res_status_o = 3'(out_status_q);

  `IEE_ASSERT_NOW(a_op_count_range, opcnt_q != '0 && opcnt_q <= CW'(STACK_DEPTH), "operator count out of range")
  `IEE_ASSERT_IMP(a_err_value_zero, out_valid_q && out_status_q != ST_OK, out_value_q == '0, "error item with nonzero value")
  `IEE_ASSERT_NXT(a_emit_clears, cmd_i.emit, opcnt_q == CW'(1) && opdcnt_q == '0, "stacks not cleared after item")

endmodule

>>> sv/iee_ctrl.sv
// Evaluator controller: character decode, precedence and reduction sequencing.
module iee_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       in_char_i,
  output logic             in_ready_o,
  input  iee_pkg::dp_sts_t sts_i,
  output iee_pkg::dp_cmd_t cmd_o
);
  import iee_pkg::*;

  typedef enum logic [3:0] {
    CL_DIGIT, CL_POINT, CL_ADD, CL_SUB, CL_MUL, CL_DIV,
    CL_OPEN, CL_CLOSE, CL_END, CL_OTHER
  } cls_e;

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_TOP, S_DEC, S_EXEC, S_MDW, S_EMIT
  } state_e;

  function automatic cls_e classify(input logic [7:0] c);
    cls_e r;
    if (c >= CH_ZERO && c <= CH_NINE) r = CL_DIGIT;
    else begin
      case (c) inside
        CH_POINT:         r = CL_POINT;
        CH_PLUS:          r = CL_ADD;
        CH_MINUS:         r = CL_SUB;
        CH_STAR:          r = CL_MUL;
        CH_SLASH:         r = CL_DIV;
        CH_OPEN:          r = CL_OPEN;
        CH_CLOSE:         r = CL_CLOSE;
        CH_EQUAL, CH_HASH: r = CL_END;
        default:          r = CL_OTHER;
      endcase
    end
    return r;
  endfunction

  state_e  state_q, state_d;
  cls_e    cls_q, cls_d;
  op_e     red_op_q, red_op_d;
  status_e code_q, code_d;
  logic    disc_q, disc_d;

  cls_e    cls_in;
  logic    accept;
  logic    top_arith, top_muldiv, do_reduce, do_push;
  op_e     push_code;

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign cls_in     = classify(in_char_i);

  assign top_arith  = sts_i.top == OP_ADD || sts_i.top == OP_SUB ||
                      sts_i.top == OP_MUL || sts_i.top == OP_DIV;
  assign top_muldiv = sts_i.top == OP_MUL || sts_i.top == OP_DIV;

  always_comb begin
    case (cls_q) inside
      CL_ADD:  push_code = OP_ADD;
      CL_SUB:  push_code = OP_SUB;
      CL_MUL:  push_code = OP_MUL;
      CL_DIV:  push_code = OP_DIV;
      default: push_code = OP_OPEN;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    cls_d    = cls_q;
    red_op_d = red_op_q;
    code_d   = code_q;
    disc_d   = disc_q;
    do_reduce = 1'b0;
    do_push   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (disc_q) begin
            if (cls_in == CL_END) disc_d = 1'b0;
          end else begin
            case (cls_in) inside
              CL_DIGIT: cmd_o.num_digit = 1'b1;
              CL_POINT: begin
                if (sts_i.point_seen) begin
                  code_d  = ST_SYNTAX;
                  state_d = S_EMIT;
                end else begin
                  cmd_o.num_point = 1'b1;
                end
              end
              CL_OTHER: ;
              default: begin
                cls_d = cls_in;
                if (!sts_i.digit_seen) begin
                  cmd_o.num_clear = 1'b1;
                  state_d = S_TOP;
                end else if (sts_i.opd_full) begin
                  code_d  = ST_OVERFLOW;
                  state_d = S_EMIT;
                end else begin
                  cmd_o.md_start = 1'b1;
                  cmd_o.md_mode  = MD_CONV;
                  state_d = S_CONV;
                end
              end
            endcase
          end
        end
      end
      S_CONV: begin
        if (sts_i.md_done) begin
          cmd_o.opd_push  = 1'b1;
          cmd_o.num_clear = 1'b1;
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        cmd_o.op_read = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        case (cls_q) inside
          CL_ADD, CL_SUB: begin
            if (top_arith) do_reduce = 1'b1;
            else do_push = 1'b1;
          end
          CL_MUL, CL_DIV: begin
            if (top_muldiv) do_reduce = 1'b1;
            else do_push = 1'b1;
          end
          CL_OPEN: do_push = 1'b1;
          CL_CLOSE: begin
            if (top_arith) do_reduce = 1'b1;
            else if (sts_i.top == OP_OPEN) begin
              cmd_o.op_pop = 1'b1;
              state_d = S_IDLE;
            end else begin
              code_d  = ST_SYNTAX;
              state_d = S_EMIT;
            end
          end
          default: begin
            if (top_arith) do_reduce = 1'b1;
            else if (sts_i.top == OP_OPEN || !sts_i.opd_is1) begin
              code_d  = ST_SYNTAX;
              state_d = S_EMIT;
            end else begin
              // fetch the single operand, then emit it
              cmd_o.opd_read = 1'b1;
              code_d  = ST_OK;
              state_d = S_EMIT;
            end
          end
        endcase
        if (do_reduce) begin
          cmd_o.op_pop = 1'b1;
          red_op_d = sts_i.top;
          if (sts_i.opd_lt2) begin
            code_d  = ST_UNDERFLOW;
            state_d = S_EMIT;
          end else begin
            cmd_o.opd_read = 1'b1;
            state_d = S_EXEC;
          end
        end
        if (do_push) begin
          if (sts_i.op_full) begin
            code_d  = ST_OVERFLOW;
            state_d = S_EMIT;
          end else begin
            cmd_o.op_push = 1'b1;
            cmd_o.op_code = push_code;
            state_d = S_IDLE;
          end
        end
      end
      S_EXEC: begin
        case (red_op_q) inside
          OP_MUL: begin
            cmd_o.md_start = 1'b1;
            cmd_o.md_mode  = MD_MUL;
            state_d = S_MDW;
          end
          OP_DIV: begin
            if (sts_i.b_zero) begin
              code_d  = ST_DIV_ZERO;
              state_d = S_EMIT;
            end else begin
              cmd_o.md_start = 1'b1;
              cmd_o.md_mode  = MD_DIV;
              state_d = S_MDW;
            end
          end
          default: begin
            cmd_o.opd_reduce = 1'b1;
            cmd_o.alu_sub    = red_op_q == OP_SUB;
            state_d = S_TOP;
          end
        endcase
      end
      S_MDW: begin
        if (sts_i.md_done) begin
          cmd_o.opd_reduce  = 1'b1;
          cmd_o.red_from_md = 1'b1;
          state_d = S_TOP;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = code_q;
          cmd_o.clear       = 1'b1;
          disc_d  = code_q != ST_OK;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cls_q    <= CL_OTHER;
      red_op_q <= OP_END;
      code_q   <= ST_OK;
      disc_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cls_q    <= cls_d;
      red_op_q <= red_op_d;
      code_q   <= code_d;
      disc_q   <= disc_d;
    end
  end

endmodule

>>> sv/infix_expression_evaluator.sv
// Top level of the infix expression evaluator: controller plus datapath.
// Digits, points and ignored characters are taken while idle; an operator first converts a
// pending number, then runs the add/sub, multiply and divide reductions that precedence calls for.
// An item is emitted once the output register is free.
// The bit-serial divider sets the worst case.
// Reset empties both stacks and the number state at once; no clearing pass is needed.
module infix_expression_evaluator #(
  parameter int STACK_DEPTH         = 64,
  parameter int FRACTION_BITS       = 16,
  parameter int MAX_FRACTION_DIGITS = 6
) (
  input logic       clk_i,
  input logic       rst_ni,
  iee_char_if.sink  char_i,
  iee_res_if.source res_o
);
  import iee_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  iee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_char_i  (char_i.character),
    .in_ready_o (char_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iee_datapath #(
    .STACK_DEPTH         (STACK_DEPTH),
    .FRACTION_BITS       (FRACTION_BITS),
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .char_i       (char_i.character),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .res_value_o  (res_o.value),
    .res_status_o (res_o.status)
  );

endmodule

>>> tb/tb_infix_expression_evaluator.sv
// Testbench for the infix expression evaluator: character stimulus, prediction and checking.
`timescale 1ns / 100ps

module tb_infix_expression_evaluator;
  import iee_pkg::*;

  localparam int DEPTH     = 64;
  localparam int FRAC      = 16;
  localparam int MAX_FD    = 6;
  localparam int LIMIT     = 3000000;
  localparam int DRAIN     = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  iee_char_if char_if ();
  iee_res_if  res_if ();

  infix_expression_evaluator i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .char_i(char_if),
    .res_o (res_if)
  );

  always #5 clk_i = ~clk_i;

  typedef struct {
    val_t    value;
    status_e status;
  } outcome_t;

  outcome_t pending_q[$];
  int       errors;
  int       cycles;
  int       n_chars;
  int       n_good;
  int       n_fault;
  int       burst_left;

  // Evaluator state as the block should hold it.
  op_e         op_stk[DEPTH];
  int          op_cnt;
  val_t        opd_stk[DEPTH];
  int          opd_cnt;
  logic [47:0] mant;
  int          frac_cnt;
  bit          point_seen;
  bit          digit_seen;
  bit          discarding;

  function automatic void clear_eval();
    for (int i = 0; i < DEPTH; i++) begin
      op_stk[i]  = OP_END;
      opd_stk[i] = '0;
    end
    op_cnt     = 1;
    opd_cnt    = 0;
    mant       = '0;
    frac_cnt   = 0;
    point_seen = 1'b0;
    digit_seen = 1'b0;
  endfunction

  function automatic logic [127:0] magnitude(input val_t v);
    longint x;
    x = longint'(v);
    return (x < 0) ? 128'(-x) : 128'(x);
  endfunction

  function automatic val_t signed_sat(input bit neg, input logic [127:0] m);
    if (neg) return (m >= 128'h8000_0000_0000) ? VAL_MIN : val_t'(-$signed({1'b0, m[47:0]}));
    return (m > 128'(VAL_MAX)) ? VAL_MAX : val_t'(m[47:0]);
  endfunction

  function automatic val_t clip48(input longint x);
    if (x > longint'(VAL_MAX)) return VAL_MAX;
    if (x < longint'(VAL_MIN)) return VAL_MIN;
    return val_t'(x);
  endfunction

  function automatic val_t fixed_mul(input val_t a, input val_t b);
    logic [127:0] p;
    p = magnitude(a) * magnitude(b);
    if ((p >> (64 + FRAC)) != 0) p = 128'h1_0000_0000_0000;
    else p = p >> FRAC;
    return signed_sat(a[47] != b[47], p);
  endfunction

  function automatic val_t fixed_div(input val_t a, input val_t b);
    logic [127:0] ma, mb, q;
    ma = magnitude(a);
    mb = magnitude(b);
    q  = ma / mb;
    if ((q >> (47 - FRAC)) != 0) q = 128'h1_0000_0000_0000;
    else q = (ma << FRAC) / mb;
    return signed_sat(a[47] != b[47], q);
  endfunction

  function automatic op_e top_op();
    return (op_cnt == 0) ? OP_END : op_stk[op_cnt-1];
  endfunction

  function automatic bit is_arith(input op_e o);
    return o inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
  endfunction

  function automatic longint pow_ten(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  function automatic status_e push_operand_from_number();
    logic [127:0] p, ip, rem, f, t;
    val_t v;
    p   = 128'(pow_ten(frac_cnt));
    ip  = 128'(mant) / p;
    rem = 128'(mant) % p;
    if (opd_cnt >= DEPTH) return ST_OVERFLOW;
    if (ip > (128'(VAL_MAX) >> FRAC)) begin
      v = VAL_MAX;
    end else begin
      f = ((rem << FRAC) + p / 2) / p;
      t = (ip << FRAC) + f;
      v = (t > 128'(VAL_MAX)) ? VAL_MAX : val_t'(t[47:0]);
    end
    opd_stk[opd_cnt] = v;
    opd_cnt++;
    return ST_OK;
  endfunction

  function automatic status_e apply_top();
    op_e  o;
    val_t a, b, r;
    o = top_op();
    if (op_cnt > 0) op_cnt--;
    if (opd_cnt < 2) return ST_UNDERFLOW;
    b = opd_stk[opd_cnt-1];
    a = opd_stk[opd_cnt-2];
    case (o)
      OP_ADD: r = clip48(longint'(a) + longint'(b));
      OP_SUB: r = clip48(longint'(a) - longint'(b));
      OP_MUL: r = fixed_mul(a, b);
      default: begin
        if (b == 0) return ST_DIV_ZERO;
        r = fixed_div(a, b);
      end
    endcase
    opd_stk[opd_cnt-2] = r;
    opd_cnt--;
    return ST_OK;
  endfunction

  function automatic status_e push_operator(input op_e o);
    if (op_cnt >= DEPTH) return ST_OVERFLOW;
    op_stk[op_cnt] = o;
    op_cnt++;
    return ST_OK;
  endfunction

  // Advance the evaluator by one character; return 1 when it emits a result.
  function automatic bit eval_char(input logic [7:0] c, output outcome_t res);
    bit      is_end;
    status_e e;
    op_e     t;
    longint  d;
    is_end = (c == CH_EQUAL) || (c == CH_HASH);
    e = ST_OK;
    res.value  = '0;
    res.status = ST_OK;
    if (discarding) begin
      if (is_end) discarding = 1'b0;
      return 0;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = longint'(c - CH_ZERO);
      digit_seen = 1'b1;
      if (point_seen) begin
        if (frac_cnt >= MAX_FD) return 0;
        frac_cnt++;
      end
      if (longint'(mant) > (longint'(VAL_MAX) - d) / 10) mant = 48'(VAL_MAX);
      else mant = 48'(longint'(mant) * 10 + d);
      return 0;
    end
    if (c == CH_POINT) begin
      if (point_seen) begin
        e = ST_SYNTAX;
      end else begin
        point_seen = 1'b1;
        return 0;
      end
    end else if (!(is_end || c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                        CH_OPEN, CH_CLOSE})) begin
      return 0;
    end else begin
      if (digit_seen) e = push_operand_from_number();
      mant       = '0;
      frac_cnt   = 0;
      point_seen = 1'b0;
      digit_seen = 1'b0;
      if (e == ST_OK) begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          while (e == ST_OK && is_arith(top_op())) e = apply_top();
          if (e == ST_OK) e = push_operator((c == CH_PLUS) ? OP_ADD : OP_SUB);
        end else if (c == CH_STAR || c == CH_SLASH) begin
          while (e == ST_OK && top_op() inside {OP_MUL, OP_DIV}) e = apply_top();
          if (e == ST_OK) e = push_operator((c == CH_STAR) ? OP_MUL : OP_DIV);
        end else if (c == CH_OPEN) begin
          e = push_operator(OP_OPEN);
        end else begin
          while (e == ST_OK && is_arith(top_op())) e = apply_top();
          t = top_op();
          if (e == ST_OK) begin
            if (c == CH_CLOSE) begin
              if (t == OP_OPEN) op_cnt--;
              else e = ST_SYNTAX;
            end else if (t == OP_OPEN || opd_cnt != 1) begin
              e = ST_SYNTAX;
            end else begin
              res.value = opd_stk[0];
              clear_eval();
              return 1;
            end
          end
        end
      end
    end
    if (e == ST_OK) return 0;
    clear_eval();
    discarding = 1'b1;
    res.status = e;
    return 1;
  endfunction

  // Send one character, with bursts and random gaps on the valid side.
  task automatic send_char(input logic [7:0] c);
    logic     rdy;
    outcome_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        char_if.valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
    burst_left--;
    char_if.valid     <= 1'b1;
    char_if.character <= c;
    do begin
      @(negedge clk_i);
      rdy = char_if.ready;
      @(posedge clk_i);
    end while (!rdy);
    n_chars++;
    if (eval_char(c, res)) pending_q.push_back(res);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic string rand_number();
    string s;
    int    nd;
    nd = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 18) : $urandom_range(1, 3);
    s = "";
    for (int i = 0; i < nd; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
    if ($urandom_range(0, 2) == 0) begin
      s = {s, "."};
      repeat ($urandom_range(0, 8)) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
    end
    return s;
  endfunction

  function automatic string rand_expr(input int lvl);
    string s, ops;
    ops = "+-*/";
    s = "";
    for (int i = 0; i < $urandom_range(1, 4); i++) begin
      if (i > 0) s = {s, string'(ops[$urandom_range(0, 3)])};
      if ($urandom_range(0, 9) == 0) s = {s, " "};
      if (lvl > 0 && $urandom_range(0, 3) == 0) s = {s, "(", rand_expr(lvl - 1), ")"};
      else s = {s, rand_number()};
    end
    return s;
  endfunction

  function automatic string end_marker();
    return $urandom_range(0, 1) ? "=" : "#";
  endfunction

  task automatic test_directed();
    string s;
    send_text("=");
    send_text("1+2*3=");
    send_text("(1+2)*3#");
    send_text("7/2-10=");
    send_text("1..5=");
    send_text("12 a3=");
    send_text("2)=");
    send_text("(2=");
    send_text("+=");
    send_text("5/0=");
    send_text("9/(3-3)#");
    send_text("99999999999999999999*99999=");
    send_text("0-99999999999*99999=");
    send_text("1/0.0000001=");
    send_text("0.123456789+.5=");
    send_text("3.00000051=");
    send_text(". +4=");
    s = "";
    repeat (DEPTH + 1) s = {s, "("};
    send_text({s, "="});
    s = "";
    repeat (DEPTH + 1) s = {s, "1+("};
    send_text({s, "="});
    send_text("4*5=");
    send_text("255\377\200=");
  endtask

  task automatic test_random_expressions(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      string s;
      s = {rand_expr(3), end_marker()};
      sent += s.len();
      send_text(s);
    end
  endtask

  task automatic test_broken_expressions(input int budget);
    string sym;
    int    sent;
    sym = "+-*/().=#0 x";
    sent = 0;
    while (sent < budget) begin
      string s;
      s = rand_expr(2);
      s[$urandom_range(0, s.len() - 1)] = sym[$urandom_range(0, sym.len() - 1)];
      s = {s, end_marker()};
      sent += s.len();
      send_text(s);
    end
  endtask

  task automatic test_noise(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      repeat ($urandom_range(1, 10)) begin
        send_char(8'($urandom_range(0, 255)));
        sent++;
      end
      send_char(CH_EQUAL);
      sent++;
    end
  endtask

  // Receiver stall pattern: phases of always-ready, random, and long stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      case ((cycles / 300) % 3)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= 1'($urandom_range(0, 1));
        default: res_if.ready <= ((cycles % 11) < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("infix_expression_evaluator: mismatch");
      $finish;
    end
  end

  // Compare each accepted result with the oldest expected one.
  always @(negedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result value=%0d status=%0d", res_if.value, res_if.status);
        errors++;
      end else begin
        outcome_t exp_r;
        exp_r = pending_q.pop_front();
        if (res_if.value !== exp_r.value) begin
          $error("value: expected %0d, got %0d", exp_r.value, res_if.value);
          errors++;
        end
        if (res_if.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, res_if.status);
          errors++;
        end
        if (exp_r.status == ST_OK) n_good++;
        else n_fault++;
      end
    end
  end

  initial begin
    errors            = 0;
    n_chars           = 0;
    n_good            = 0;
    n_fault           = 0;
    burst_left        = 0;
    discarding        = 1'b0;
    char_if.valid     = 1'b0;
    char_if.character = '0;
    clear_eval();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_expressions(950);
    test_broken_expressions(350);
    test_noise(250);
    char_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("Sent %0d characters; checked %0d good results and %0d error results.",
             n_chars, n_good, n_fault);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("infix_expression_evaluator: match");
    end else begin
      $display("infix_expression_evaluator: mismatch");
    end
    $finish;
  end

endmodule
